### src/pit_pkg.sv
// Shared constants and types for the point-in-triangle test pipeline.
// No dependencies; used by pit_mul and the top level.
`default_nettype none

package pit_pkg;

	localparam int FIELD_W  = 63;   // packed vector field width
	localparam int TOL_W    = 20;   // plane tolerance register width
	localparam int FRAC_W   = 10;   // Q10.10 fraction bits
	localparam int DQ_W     = 21;   // rounded plane distance kept past the tolerance check
	localparam int LIMB_W   = 30;   // operand slice width of the split multiplier
	localparam int MUL_LAT  = 3;    // split multiplier latency

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

	typedef struct packed {
		logic pp;    // partial product register load
		logic row;   // row sum register load
		logic sum;   // final sum register load
	} mul_en_t;

endpackage

`default_nettype wire

### src/pit_mul.sv
// Pipelined signed multiplier split into LIMB_W slices: partial products,
// row sums, final sum, one register each. Depends on pit_pkg.
`default_nettype none

module pit_mul #(
	parameter int A_W = 42,
	parameter int B_W = 42
) (
	input  logic                      clk,
	input  pit_pkg::mul_en_t          en,
	input  logic signed [A_W-1:0]     a,
	input  logic signed [B_W-1:0]     b,
	output logic signed [A_W+B_W-1:0] p
);

	localparam int L    = pit_pkg::LIMB_W;
	localparam int NA   = (A_W + L - 1) / L;
	localparam int NB   = (B_W + L - 1) / L;
	localparam int AX_W = NA * L;
	localparam int BX_W = NB * L;
	localparam int P_W  = A_W + B_W;
	localparam int PP_W = 2 * L + 2;

	logic signed [AX_W-1:0] ax;
	logic signed [BX_W-1:0] bx;
	logic signed [L:0]      la [NA];
	logic signed [L:0]      lb [NB];
	logic signed [PP_W-1:0] pp_s1 [NA][NB];
	logic signed [P_W-1:0]  row_c [NA];
	logic signed [P_W-1:0]  row_s2 [NA];
	logic signed [P_W-1:0]  sum_c;
	logic signed [P_W-1:0]  p_s3;

	assign ax = AX_W'(a);
	assign bx = BX_W'(b);

	// lower slices are unsigned, the top slice carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1) begin
				la[i] = {ax[AX_W-1], ax[i*L +: L]};
			end else begin
				la[i] = {1'b0, ax[i*L +: L]};
			end
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1) begin
				lb[j] = {bx[BX_W-1], bx[j*L +: L]};
			end else begin
				lb[j] = {1'b0, bx[j*L +: L]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.pp) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= la[i] * lb[j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (P_W'(pp_s1[i][j]) <<< (j * L));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.row) begin
			row_s2 <= row_c;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (row_s2[i] <<< (i * L));
		end
	end

	always_ff @(posedge clk) begin
		if (en.sum) begin
			p_s3 <= sum_c;
		end
	end

	assign p = p_s3;

endmodule

`default_nettype wire

### src/point_in_triangle_test_top.sv
// Point-in-triangle test in 3D: plane distance check, projection, edge
// cross products and their dot-product signs. Depends on pit_pkg, pit_mul.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid / in_stall     | vertex_a, vertex_b, vertex_c,
//           |                         | plane_normal, query_point
//   out     | out_valid / out_stall   | inside_res
//   cfg     | cfg_we                  | cfg_wdata (plane_tolerance)
//
// One item per cycle while out_stall is low.
// The pipeline runs the distance and projection stages, then the two split
// multiplier stages (cross products, then dot products).
// Reset clears the stage valid bits; plane_tolerance resets to 1.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and in_stall only rises with every stage full and out_stall high.
`default_nettype none

module point_in_triangle_test_top #(
	parameter int COORD_WIDTH = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pit_pkg::TOL_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pit_pkg::FIELD_W-1:0]  vertex_a,
	input  logic [pit_pkg::FIELD_W-1:0]  vertex_b,
	input  logic [pit_pkg::FIELD_W-1:0]  vertex_c,
	input  logic [pit_pkg::FIELD_W-1:0]  plane_normal,
	input  logic [pit_pkg::FIELD_W-1:0]  query_point,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         inside_res
);

	localparam int W     = COORD_WIDTH;
	localparam int FW    = pit_pkg::FRAC_W;
	localparam int TW    = pit_pkg::TOL_W;
	localparam int QW    = pit_pkg::DQ_W;
	localparam int NSTG  = 10 + pit_pkg::MUL_LAT;
	localparam int DW    = 2 * W + 3;
	localparam int DQF   = DW + 1 - FW;
	localparam int CMPW  = ((DQF > TW) ? DQF : TW) + 2;
	localparam int NDW   = W + QW;
	localparam int RW    = W + 21;
	localparam int CW    = 2 * RW + 1;
	localparam int DOTW  = 2 * CW + 2;
	localparam int HALF  = 1 << (FW - 1);
	localparam int S_CRS = 6;                          // first cross multiplier stage
	localparam int S_C   = S_CRS + pit_pkg::MUL_LAT;   // cross vector stage
	localparam int S_DOT = S_C + 1;                    // first dot multiplier stage

	// control
	logic [TW-1:0]   tol_q;
	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] ld;

	// unpacked inputs: 0 a, 1 b, 2 c, 3 normal, 4 point
	logic [pit_pkg::FIELD_W-1:0] fld [5];
	logic signed [W-1:0]         cmp_in [5][3];

	logic signed [2*W-1:0]  pn_s1 [3];
	logic signed [2*W-1:0]  an_s1 [3];
	logic signed [W:0]      dif_s1 [3][3];
	logic signed [W-1:0]    nrm_s1 [3];

	logic signed [DW-1:0]   d20_s2;
	logic signed [W:0]      dif_s2 [3][3];
	logic signed [W-1:0]    nrm_s2 [3];

	logic signed [DW:0]     rnd;
	logic signed [DQF-1:0]  dq_full;
	logic signed [CMPW-1:0] dq_x;
	logic signed [CMPW-1:0] tol_pos;
	logic signed [CMPW-1:0] tol_neg;

	logic signed [QW-1:0]   dq_s3;
	logic signed [W:0]      dif_s3 [3][3];
	logic signed [W-1:0]    nrm_s3 [3];

	logic signed [NDW-1:0]  nd_s4 [3];
	logic signed [W:0]      dif_s4 [3][3];

	logic signed [RW-1:0]   u_s5 [3][3];

	logic signed [2*RW-1:0] mpa [3][3];
	logic signed [2*RW-1:0] mpb [3][3];
	logic signed [CW-1:0]   c_s9 [3][3];

	logic signed [2*CW-1:0] dp [2][3];
	logic signed [DOTW-1:0] dot0;
	logic signed [DOTW-1:0] dot1;

	logic                   ok_s [3:NSTG-1];
	logic                   res_s13;

	pit_pkg::mul_en_t       crs_en;
	pit_pkg::mul_en_t       dot_en;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= pit_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// stage loads ripple back from the output
	assign ld[NSTG+1] = !out_stall;
	for (genvar k = 1; k <= NSTG; k++) begin : g_ld
		assign ld[k] = !vld_s[k] || ld[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_stall  = !ld[1];
	assign out_valid = vld_s[NSTG];
	assign inside_res = res_s13;

	assign fld[0] = vertex_a;
	assign fld[1] = vertex_b;
	assign fld[2] = vertex_c;
	assign fld[3] = plane_normal;
	assign fld[4] = query_point;

	for (genvar v = 0; v < 5; v++) begin : g_unp
		for (genvar k = 0; k < 3; k++) begin : g_cmp
			assign cmp_in[v][k] = fld[v][k*W +: W];
		end
	end

	// s1: distance products, vertex minus point
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int k = 0; k < 3; k++) begin
				pn_s1[k]  <= cmp_in[4][k] * cmp_in[3][k];
				an_s1[k]  <= cmp_in[0][k] * cmp_in[3][k];
				nrm_s1[k] <= cmp_in[3][k];
				for (int v = 0; v < 3; v++) begin
					dif_s1[v][k] <= (W+1)'(cmp_in[v][k]) - (W+1)'(cmp_in[4][k]);
				end
			end
		end
	end

	// s2: Q20.20 plane distance
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			d20_s2 <= DW'(pn_s1[0]) + DW'(pn_s1[1]) + DW'(pn_s1[2])
				- DW'(an_s1[0]) - DW'(an_s1[1]) - DW'(an_s1[2]);
			dif_s2 <= dif_s1;
			nrm_s2 <= nrm_s1;
		end
	end

	// s3: round to Q10.10, ties up; tolerance check
	assign rnd     = (DW+1)'(d20_s2) + (DW+1)'(HALF);
	assign dq_full = rnd[DW:FW];
	assign dq_x    = CMPW'(dq_full);
	assign tol_pos = $signed({{(CMPW-TW){1'b0}}, tol_q});
	assign tol_neg = -tol_pos;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			dq_s3    <= QW'(dq_full);
			ok_s[3]  <= (dq_x <= tol_pos) && (dq_x >= tol_neg);
			dif_s3   <= dif_s2;
			nrm_s3   <= nrm_s2;
		end
	end

	// s4: normal times distance
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			for (int k = 0; k < 3; k++) begin
				nd_s4[k] <= nrm_s3[k] * dq_s3;
			end
			dif_s4 <= dif_s3;
		end
	end

	// s5: vertex relative to projected point, Q20.20
	always_ff @(posedge clk) begin
		if (ld[5]) begin
			for (int v = 0; v < 3; v++) begin
				for (int k = 0; k < 3; k++) begin
					u_s5[v][k] <= (RW'(dif_s4[v][k]) <<< FW) + RW'(nd_s4[k]);
				end
			end
		end
	end

	for (genvar k = 4; k < NSTG; k++) begin : g_ok
		always_ff @(posedge clk) begin
			if (ld[k]) begin
				ok_s[k] <= ok_s[k-1];
			end
		end
	end

	assign crs_en.pp  = ld[S_CRS];
	assign crs_en.row = ld[S_CRS+1];
	assign crs_en.sum = ld[S_CRS+2];
	assign dot_en.pp  = ld[S_DOT];
	assign dot_en.row = ld[S_DOT+1];
	assign dot_en.sum = ld[S_DOT+2];

	// edge cross products: edge e pairs vertex e with vertex e+1
	for (genvar e = 0; e < 3; e++) begin : g_edge
		for (genvar k = 0; k < 3; k++) begin : g_axis
			localparam int V1 = (e + 1) % 3;
			localparam int I1 = (k + 1) % 3;
			localparam int I2 = (k + 2) % 3;

			pit_mul #(.A_W(RW), .B_W(RW)) u_mul_a (
				.clk (clk),
				.en  (crs_en),
				.a   (u_s5[e][I1]),
				.b   (u_s5[V1][I2]),
				.p   (mpa[e][k])
			);

			pit_mul #(.A_W(RW), .B_W(RW)) u_mul_b (
				.clk (clk),
				.en  (crs_en),
				.a   (u_s5[e][I2]),
				.b   (u_s5[V1][I1]),
				.p   (mpb[e][k])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[S_C]) begin
			for (int e = 0; e < 3; e++) begin
				for (int k = 0; k < 3; k++) begin
					c_s9[e][k] <= CW'(mpa[e][k]) - CW'(mpb[e][k]);
				end
			end
		end
	end

	// dot(c1,c2) and dot(c2,c3)
	for (genvar g = 0; g < 2; g++) begin : g_dot
		for (genvar k = 0; k < 3; k++) begin : g_axis
			pit_mul #(.A_W(CW), .B_W(CW)) u_mul (
				.clk (clk),
				.en  (dot_en),
				.a   (c_s9[g][k]),
				.b   (c_s9[g+1][k]),
				.p   (dp[g][k])
			);
		end
	end

	assign dot0 = DOTW'(dp[0][0]) + DOTW'(dp[0][1]) + DOTW'(dp[0][2]);
	assign dot1 = DOTW'(dp[1][0]) + DOTW'(dp[1][1]) + DOTW'(dp[1][2]);

	always_ff @(posedge clk) begin
		if (ld[NSTG]) begin
			res_s13 <= ok_s[NSTG-1] && !dot0[DOTW-1] && !dot1[DOTW-1];
		end
	end

endmodule

`default_nettype wire

### src/pit_chk.sv
// Port-level checker for point_in_triangle_test_top, bound to it below.
// Depends only on the top level's ports.
`default_nettype none

module pit_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic inside_res
);

	// a stalled result stays and holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(inside_res))
		else $error("stalled result changed");

	// input backs up only when the whole pipe is full behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in pipeline");

	// a stalled valid input implies the output was valid and stalled in the same cycle
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> $past(out_valid) && $past(out_stall))
		else $error("input stall without a full pipeline");

	// reset empties the pipeline
	a_rst: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("pipeline not empty in reset");

endmodule

bind point_in_triangle_test_top pit_chk u_pit_chk (.*);

`default_nettype wire
